FILE: rtl/dfe_pkg.sv
package dfe_pkg;

  // Default marker limits handed to the top level.
  localparam int LEFT_MAX_DEF  = 16;
  localparam int RIGHT_MAX_DEF = 8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LEFT_LOW   = 3'd0;
  localparam logic [2:0] CFG_LEFT_HIGH  = 3'd1;
  localparam logic [2:0] CFG_LEFT_LEN   = 3'd2;
  localparam logic [2:0] CFG_RIGHT_PAT  = 3'd3;
  localparam logic [2:0] CFG_RIGHT_LEN  = 3'd4;
  localparam logic [2:0] CFG_DIVIDER    = 3'd5;

  // Result kind codes.
  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_DIVIDER = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
    logic       unfinished;
  } out_item_t;

  // Per-cell compare result; a cell outside the marker window reports a match.
  typedef struct packed {
    logic left_ok;
    logic right_ok;
  } cell_match_t;

  // Byte j of the left marker; bytes past the two registers read as zero.
  function automatic logic [7:0] left_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input int j);
    logic [63:0] t;
    t = '0;
    if (j >= 0 && j < 8) begin
      t = lo >> (8 * j);
    end else if (j >= 8 && j < 16) begin
      t = hi >> (8 * (j - 8));
    end
    return t[7:0];
  endfunction

  // Byte j of the right marker; bytes past the register read as zero.
  function automatic logic [7:0] right_byte(input logic [63:0] pat, input int j);
    logic [63:0] t;
    t = '0;
    if (j >= 0 && j < 8) begin
      t = pat >> (8 * j);
    end
    return t[7:0];
  endfunction

endpackage

FILE: rtl/dfe_ifs.sv
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_document;

  modport source (output valid, output in_byte, output end_of_document, input ready);
  modport sink (input valid, input in_byte, input end_of_document, output ready);
endinterface

interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;
  logic       unfinished;

  modport source (output valid, output out_byte, output kind, output last,
                  output unfinished, input ready);
  modport sink (input valid, input out_byte, input kind, input last,
                input unfinished, output ready);
endinterface

FILE: rtl/dfe_cell.sv
module dfe_cell
  import dfe_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  d_in,
  input  logic [7:0]  left_pat,
  input  logic        left_on,
  input  logic [7:0]  right_pat,
  input  logic        right_on,
  output logic [7:0]  q,
  output cell_match_t m
);

  logic [7:0] q_r;

  // The compare looks at the byte entering this cell, so the window seen is
  // the history after the current byte has been shifted in.
  always_comb begin
    m.left_ok  = !left_on || (d_in == left_pat);
    m.right_ok = !right_on || (d_in == right_pat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/dfe_skid.sv
module dfe_skid
  import dfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  out_item_t in_item,
  output logic      in_ready,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_ready
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_nxt   = in_item;
        skid_v_nxt = in_valid;
      end else begin
        main_nxt   = in_item;
        main_v_nxt = in_valid;
      end
    end else if (in_valid) begin
      skid_nxt   = in_item;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

endmodule

FILE: rtl/delimited_field_extractor.sv
// Channel  Direction  Payload                                    Handshake
// in_ch    sink       in_byte[8], end_of_document[1]             valid / ready
// out_ch   source     out_byte[8], kind[2], last[1], unfinished  valid / ready
// cfg_*    write      cfg_index[3], cfg_data[64]                 cfg_we only
//
// One byte is taken per clock cycle while the input is not held off; its
// result is registered in the output register, or in the skid stage if the
// output is stalled. The row of history cells compares all window bytes in
// parallel against both markers. Reset is synchronous and active low and
// returns every configuration register to its documented value. A stalled
// output fills a one-entry skid stage, and only then is the input held off.
module delimited_field_extractor
  import dfe_pkg::*;
#(
  parameter int LEFT_MAX  = LEFT_MAX_DEF,
  parameter int RIGHT_MAX = RIGHT_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dfe_in_if.sink       in_ch,
  dfe_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  // The history row must hold the longer of the two markers.
  localparam int HIST_DEPTH = (LEFT_MAX > RIGHT_MAX) ? LEFT_MAX : RIGHT_MAX;
  localparam int FW = $clog2(HIST_DEPTH + 1);
  localparam int LW = $clog2(LEFT_MAX + 1);
  localparam int RW = $clog2(RIGHT_MAX + 1);

  // Configuration registers.
  logic [63:0] left_lo_r;
  logic [63:0] left_hi_r;
  logic [4:0]  lmark_size_r;
  logic [63:0] right_pat_r;
  logic [3:0]  rmark_size_r;
  logic [7:0]  divider_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_lo_r    <= '0;
      left_hi_r    <= '0;
      lmark_size_r <= 5'd1;
      right_pat_r  <= '0;
      rmark_size_r <= 4'd1;
      divider_r    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_LOW:  left_lo_r    <= cfg_data;
        CFG_LEFT_HIGH: left_hi_r    <= cfg_data;
        CFG_LEFT_LEN:  lmark_size_r <= cfg_data[4:0];
        CFG_RIGHT_PAT: right_pat_r  <= cfg_data;
        CFG_RIGHT_LEN: rmark_size_r <= cfg_data[3:0];
        CFG_DIVIDER:   divider_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Effective marker lengths. A length of zero acts as one, and a length
  // above what the history can hold saturates at the limit.
  logic [LW-1:0] len_l;
  logic [RW-1:0] len_r;

  always_comb begin
    if (lmark_size_r == '0) begin
      len_l = LW'(1);
    end else if (int'(lmark_size_r) > LEFT_MAX) begin
      len_l = LW'(LEFT_MAX);
    end else begin
      len_l = LW'(lmark_size_r);
    end
    if (rmark_size_r == '0) begin
      len_r = RW'(1);
    end else if (int'(rmark_size_r) > RIGHT_MAX) begin
      len_r = RW'(RIGHT_MAX);
    end else begin
      len_r = RW'(rmark_size_r);
    end
  end

  // Marker bytes lined up with the history cells. The newest byte sits in
  // cell 0, so cell k faces marker byte (length - 1 - k). Cells beyond the
  // marker length take no part in the match.
  logic [7:0] left_pat  [HIST_DEPTH];
  logic [7:0] right_pat [HIST_DEPTH];
  logic       left_on   [HIST_DEPTH];
  logic       right_on  [HIST_DEPTH];

  always_comb begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      left_on[k]   = k < int'(len_l);
      right_on[k]  = k < int'(len_r);
      left_pat[k]  = left_byte(left_lo_r, left_hi_r, int'(len_l) - 1 - k);
      right_pat[k] = right_byte(right_pat_r, int'(len_r) - 1 - k);
    end
  end

  // The row of history cells. Each cell passes its byte to the next one on
  // every accepted transaction.
  logic        accept;
  logic [7:0]  hist_in [HIST_DEPTH];
  logic [7:0]  hist_q  [HIST_DEPTH];
  cell_match_t cell_m  [HIST_DEPTH];

  assign accept = in_ch.valid && in_ch.ready;

  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign hist_in[k] = in_ch.in_byte;
    end else begin : g_body
      assign hist_in[k] = hist_q[k-1];
    end

    dfe_cell u_cell (
      .clk       (clk),
      .en        (accept),
      .d_in      (hist_in[k]),
      .left_pat  (left_pat[k]),
      .left_on   (left_on[k]),
      .right_pat (right_pat[k]),
      .right_on  (right_on[k]),
      .q         (hist_q[k]),
      .m         (cell_m[k])
    );
  end

  logic all_left_ok;
  logic all_right_ok;
  logic [7:0] held_byte;

  always_comb begin
    all_left_ok  = 1'b1;
    all_right_ok = 1'b1;
    held_byte    = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      all_left_ok  = all_left_ok && cell_m[k].left_ok;
      all_right_ok = all_right_ok && cell_m[k].right_ok;
      // The oldest byte in the right-marker window is the one released.
      if (k == int'(len_r) - 1) begin
        held_byte = hist_in[k];
      end
    end
  end

  // Document state.
  logic          capturing_r, capturing_nxt;
  logic          field_seen_r, field_seen_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [RW-1:0] held_r, held_nxt;

  logic [FW-1:0] fill_inc;
  logic [RW-1:0] held_inc;
  logic          left_hit;
  logic          right_hit;
  logic          emit_content;
  logic          emit_div;
  logic          eod;
  logic          res_valid;
  out_item_t     res_item;
  logic          buf_ready;

  always_comb begin
    eod      = in_ch.end_of_document;
    fill_inc = (int'(fill_r) == HIST_DEPTH) ? fill_r : fill_r + FW'(1);
    held_inc = held_r + RW'(1);

    // A marker counts only once enough bytes have arrived since the search
    // began, so the right search never reaches back into the left marker.
    left_hit  = !capturing_r && all_left_ok && (int'(fill_inc) >= int'(len_l));
    right_hit = capturing_r && all_right_ok && (int'(fill_inc) >= int'(len_r));

    // Captured bytes are released once a full right-marker length lies
    // behind them; bytes still held at a right match are marker bytes.
    emit_content = capturing_r && !right_hit && (held_inc >= len_r);
    emit_div     = left_hit && field_seen_r;

    capturing_nxt  = capturing_r;
    field_seen_nxt = field_seen_r;
    fill_nxt       = fill_inc;
    held_nxt       = held_r;
    if (left_hit) begin
      capturing_nxt = 1'b1;
      fill_nxt      = '0;
      held_nxt      = '0;
    end else if (right_hit) begin
      capturing_nxt  = 1'b0;
      field_seen_nxt = 1'b1;
      fill_nxt       = '0;
      held_nxt       = '0;
    end else if (capturing_r) begin
      held_nxt = emit_content ? (len_r - RW'(1)) : held_inc;
    end

    res_item.last       = eod;
    res_item.unfinished = eod && capturing_nxt;
    if (emit_div) begin
      res_item.out_byte = divider_r;
      res_item.kind     = KIND_DIVIDER;
    end else if (emit_content) begin
      res_item.out_byte = held_byte;
      res_item.kind     = KIND_CONTENT;
    end else begin
      res_item.out_byte = '0;
      res_item.kind     = KIND_NONE;
    end
    res_valid = accept && (emit_div || emit_content || eod);

    // The end of a document returns the search state to its reset values.
    if (eod) begin
      capturing_nxt  = 1'b0;
      field_seen_nxt = 1'b0;
      fill_nxt       = '0;
      held_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r  <= 1'b0;
      field_seen_r <= 1'b0;
      fill_r       <= '0;
      held_r       <= '0;
    end else if (accept) begin
      capturing_r  <= capturing_nxt;
      field_seen_r <= field_seen_nxt;
      fill_r       <= fill_nxt;
      held_r       <= held_nxt;
    end
  end

  // Output register with a skid stage behind it.
  out_item_t out_item;

  dfe_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_item   (res_item),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .out_ready (out_ch.ready)
  );

  assign in_ch.ready       = buf_ready;
  assign out_ch.out_byte   = out_item.out_byte;
  assign out_ch.kind       = out_item.kind;
  assign out_ch.last       = out_item.last;
  assign out_ch.unfinished = out_item.unfinished;

`ifndef NO_ASSERTIONS
  // The input is held off only while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // A result with no byte exists only to close a document.
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_NONE) |-> out_ch.last)
    else $error("empty result without end of document");

  // The unfinished flag belongs to the closing result only.
  a_unfinished_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.unfinished) |-> out_ch.last)
    else $error("unfinished flag on a result that does not end a document");

  // Closing a document clears the search state.
  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_document) |=> (!capturing_r && !field_seen_r && fill_r == '0))
    else $error("search state kept across end of document");

  // Held bytes always stay below the right-marker length.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    capturing_r |-> (held_r < len_r))
    else $error("held byte count reached the right-marker length");
`endif

endmodule
